@@ rtl/core/msc_pkg.sv @@
// ----------------------------------------------------------------------------
// Median of sample set package
// Shared widths, default depth and the control word of the sorting cells.
// ----------------------------------------------------------------------------
package msc_pkg;

    localparam int WINDOW_DEPTH = 16;
    localparam int SAMPLE_W     = 32;
    localparam int COUNT_OUT_W  = 5;

    typedef struct packed {
        logic insert;
        logic drain;
    } t_cell_ctl;

endpackage

@@ rtl/core/median_of_sample_set.sv @@
// A word without last leaves busy low, so start may follow in the next cycle.
// A word with last makes busy high while the sorted cell chain drains toward cell zero, one
// step a cycle, and the median is rounded; the result strobe rises at the edge at which busy
// falls and lasts exactly one cycle.
// Reset is synchronous and active low; it empties the set and clears the strobe.
// ----------------------------------------------------------------------------
// Median of sample set
// Keeps the samples of a set sorted in a chain of cells and gives the median,
// sample count and overflow flag once the last sample of the set has arrived.
// ----------------------------------------------------------------------------
module median_of_sample_set #(
    parameter int WINDOW_DEPTH = msc_pkg::WINDOW_DEPTH
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic signed [msc_pkg::SAMPLE_W-1:0]    i_sample,
    input  logic                                   i_last,
    output logic                                   o_valid,
    output logic signed [msc_pkg::SAMPLE_W-1:0]    o_median_value,
    output logic        [msc_pkg::COUNT_OUT_W-1:0] o_sample_count,
    output logic                                   o_overflowed
);

    localparam int CW   = $clog2(WINDOW_DEPTH + 1);
    localparam int IDX1 = (WINDOW_DEPTH > 1) ? 1 : 0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_ROUND
    } t_state;

    t_state                              r_state;
    logic [CW-1:0]                       r_count;
    logic [CW-1:0]                       r_shift;
    logic                                r_drop;
    logic signed [msc_pkg::SAMPLE_W:0]   r_sum;

    logic signed [msc_pkg::SAMPLE_W-1:0] w_val [WINDOW_DEPTH];
    logic                                w_le  [WINDOW_DEPTH];
    logic [WINDOW_DEPTH-1:0]             w_valid;
    msc_pkg::t_cell_ctl                  w_ctl;
    logic                                w_accept;
    logic                                w_room;
    logic [CW-1:0]                       w_kept;
    logic signed [msc_pkg::SAMPLE_W-1:0] w_lo_val;
    logic signed [msc_pkg::SAMPLE_W-1:0] w_hi_val;
    logic signed [msc_pkg::SAMPLE_W:0]   w_sum_adj;

    assign busy       = (r_state != ST_IDLE);
    assign w_accept   = start && !busy;
    assign w_room     = (r_count < CW'(WINDOW_DEPTH));
    assign w_kept     = w_room ? (r_count + CW'(1)) : r_count;
    assign w_ctl.insert = w_accept && w_room;
    assign w_ctl.drain  = (r_state == ST_SHIFT) && (r_shift != '0);

    assign w_lo_val  = w_val[0];
    assign w_hi_val  = r_count[0] ? w_val[0] : w_val[IDX1];
    assign w_sum_adj = r_sum + (msc_pkg::SAMPLE_W + 1)'(r_sum[msc_pkg::SAMPLE_W]);

    genvar g;
    generate
        for (g = 0; g < WINDOW_DEPTH; g++) begin : g_cell
            assign w_valid[g] = (r_count > CW'(g));
            msc_cell u_cell (
                .i_clk      (i_clk),
                .i_ctl      (w_ctl),
                .i_valid    (w_valid[g]),
                .i_sample   (i_sample),
                .i_left_le  ((g == 0) ? 1'b1 : w_le[(g == 0) ? 0 : g - 1]),
                .i_left_val (w_val[(g == 0) ? 0 : g - 1]),
                .i_right_val(w_val[(g == WINDOW_DEPTH - 1) ? g : g + 1]),
                .o_le       (w_le[g]),
                .o_val      (w_val[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_shift <= '0;
            r_drop  <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_count <= w_kept;
                        if (!w_room) begin
                            r_drop <= 1'b1;
                        end
                        if (i_last) begin
                            r_shift <= (w_kept - CW'(1)) >> 1;
                            r_state <= ST_SHIFT;
                        end
                    end
                end
                ST_SHIFT: begin
                    if (r_shift == '0) begin
                        r_sum   <= {w_lo_val[msc_pkg::SAMPLE_W-1], w_lo_val}
                                 + {w_hi_val[msc_pkg::SAMPLE_W-1], w_hi_val};
                        r_state <= ST_ROUND;
                    end else begin
                        r_shift <= r_shift - CW'(1);
                    end
                end
                ST_ROUND: begin
                    o_valid        <= 1'b1;
                    o_median_value <= w_sum_adj[msc_pkg::SAMPLE_W:1];
                    o_sample_count <= msc_pkg::COUNT_OUT_W'(r_count);
                    o_overflowed   <= r_drop;
                    r_count        <= '0;
                    r_drop         <= 1'b0;
                    r_state        <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("Result strobe while the block is busy.");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(WINDOW_DEPTH))
        else $error("Fill count beyond the chain depth.");

    a_plain_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_last) |=> !busy && !o_valid)
        else $error("A word without last did not complete in one cycle.");

    generate
        for (g = 0; g + 1 < WINDOW_DEPTH; g++) begin : g_order
            a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
                (r_state == ST_IDLE && w_valid[g + 1]) |-> (w_val[g] <= w_val[g + 1]))
                else $error("Cell chain is out of ascending order.");
        end
    endgenerate

endmodule

@@ rtl/core/msc_cell.sv @@
// ----------------------------------------------------------------------------
// Sorting cell
// Holds one sample of the ascending chain. On insert it keeps its word, takes
// the new word or takes its left neighbor's word; on drain it takes the right
// neighbor's word so that the chain moves toward cell zero.
// ----------------------------------------------------------------------------
module msc_cell (
    input  logic                                i_clk,
    input  msc_pkg::t_cell_ctl                  i_ctl,
    input  logic                                i_valid,
    input  logic signed [msc_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                                i_left_le,
    input  logic signed [msc_pkg::SAMPLE_W-1:0] i_left_val,
    input  logic signed [msc_pkg::SAMPLE_W-1:0] i_right_val,
    output logic                                o_le,
    output logic signed [msc_pkg::SAMPLE_W-1:0] o_val
);

    logic signed [msc_pkg::SAMPLE_W-1:0] r_val;
    logic signed [msc_pkg::SAMPLE_W-1:0] n_val;

    assign o_le  = i_valid && !(r_val > i_sample);
    assign o_val = r_val;

    always_comb begin
        n_val = r_val;
        if (i_ctl.insert) begin
            if (o_le) begin
                n_val = r_val;
            end else if (i_left_le) begin
                n_val = i_sample;
            end else begin
                n_val = i_left_val;
            end
        end else if (i_ctl.drain) begin
            n_val = i_right_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

@@ tb/sv/tb_median_of_sample_set.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Median of sample set testbench
// Sends directed sets, then sets of signed samples with random lengths and
// values, some of them past the store capacity, and checks median, count and
// overflow of each result against a sorted-insertion predictor kept in a scoreboard.
// ----------------------------------------------------------------------------
module tb_median_of_sample_set;

    localparam int DEPTH    = msc_pkg::WINDOW_DEPTH;
    localparam int SW       = msc_pkg::SAMPLE_W;
    localparam int CW       = msc_pkg::COUNT_OUT_W;
    localparam int N_WORDS  = 2000;
    localparam int CALM_AT  = 1700;
    localparam logic signed [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};

    typedef struct {
        logic signed [SW-1:0] median;
        logic        [CW-1:0] count;
        logic                 ovf;
    } t_median_result;

    class median_scoreboard;
        logic signed [SW-1:0] sorted_vals [DEPTH];
        int unsigned          kept;
        bit                   dropped;
        t_median_result       pending_q[$];
        int unsigned          mismatches;

        function int pending();
            return pending_q.size();
        endfunction

        function void flag(string what, longint want, longint got);
            mismatches++;
            if (mismatches <= 10) begin
                $display("%0t mismatch %s: expected %0d, actual %0d", $realtime, what, want, got);
            end
        endfunction

        function void note_word(logic signed [SW-1:0] s, logic l);
            int unsigned    pos;
            longint         pair_sum;
            t_median_result r;
            if (kept < DEPTH) begin
                pos = kept;
                while (pos > 0 && sorted_vals[pos-1] > s) begin
                    sorted_vals[pos] = sorted_vals[pos-1];
                    pos--;
                end
                sorted_vals[pos] = s;
                kept++;
            end else begin
                dropped = 1'b1;
            end
            if (l) begin
                if (kept % 2 == 0) begin
                    pair_sum = longint'(sorted_vals[kept/2-1]) + longint'(sorted_vals[kept/2]);
                    r.median = SW'(pair_sum / 2);
                end else begin
                    r.median = sorted_vals[kept/2];
                end
                r.count = CW'(kept);
                r.ovf   = dropped;
                pending_q.push_back(r);
                kept    = 0;
                dropped = 1'b0;
            end
        endfunction

        function void check_result(logic signed [SW-1:0] m, logic [CW-1:0] c, logic o);
            t_median_result w;
            if (pending_q.size() == 0) begin
                flag("unexpected result, median", 0, m);
                return;
            end
            w = pending_q.pop_front();
            if (m !== w.median) flag("median_value", w.median, m);
            if (c !== w.count)  flag("sample_count", w.count, c);
            if (o !== w.ovf)    flag("overflowed", w.ovf, o);
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic signed [SW-1:0] i_sample;
    logic                 i_last;
    logic                 o_valid;
    logic signed [SW-1:0] o_median_value;
    logic        [CW-1:0] o_sample_count;
    logic                 o_overflowed;

    median_scoreboard     sb;
    int unsigned          words_sent;
    logic signed [SW-1:0] prev_sample;

    median_of_sample_set dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_sample       (i_sample),
        .i_last         (i_last),
        .o_valid        (o_valid),
        .o_median_value (o_median_value),
        .o_sample_count (o_sample_count),
        .o_overflowed   (o_overflowed)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid) sb.check_result(o_median_value, o_sample_count, o_overflowed);
            if (start && !busy) sb.note_word(i_sample, i_last);
        end
    end

    // Called at a falling edge; returns at the falling edge after the word is taken.
    task automatic send_word(logic signed [SW-1:0] s, logic l);
        start    <= 1'b1;
        i_sample <= s;
        i_last   <= l;
        do @(posedge i_clk); while (busy);
        words_sent++;
        @(negedge i_clk);
    endtask

    task automatic idle(int unsigned n);
        start    <= 1'b0;
        i_sample <= $urandom;
        i_last   <= 1'($urandom_range(0, 1));
        repeat (n) @(negedge i_clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic signed [SW-1:0] pick_sample();
        logic signed [SW-1:0] v;
        case ($urandom_range(0, 9))
            0:       v = S_MAX;
            1:       v = S_MIN;
            2:       v = SW'($urandom_range(0, 16)) - SW'(8);
            3:       v = prev_sample;
            default: v = $urandom;
        endcase
        prev_sample = v;
        return v;
    endfunction

    task automatic send_random_set();
        int unsigned len;
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r < 14) begin
            len = $urandom_range(1, DEPTH);
        end else if (r < 16) begin
            len = DEPTH;
        end else begin
            len = $urandom_range(DEPTH + 1, DEPTH + 8);
        end
        for (int unsigned k = 0; k < len; k++) begin
            if (words_sent < CALM_AT && $urandom_range(0, 3) == 0) begin
                idle($urandom_range(1, 4));
            end
            send_word(pick_sample(), k == len - 1);
        end
    endtask

    initial begin
        sb          = new();
        words_sent  = 0;
        prev_sample = '0;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_sample    = '0;
        i_last      = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Single-sample sets at both extremes.
        send_word(S_MAX, 1'b1);
        send_word(S_MIN, 1'b1);
        // Even pairs whose sum needs the extra bit, and rounding toward zero.
        send_word(S_MAX, 1'b0);
        send_word(S_MAX, 1'b1);
        send_word(S_MIN, 1'b0);
        send_word(S_MIN, 1'b1);
        send_word(S_MIN, 1'b0);
        send_word(S_MAX, 1'b1);
        send_word(-32'sd3, 1'b0);
        send_word(32'sd0, 1'b1);
        // Odd set with a repeated value, then a descending even set.
        send_word(32'sd5, 1'b0);
        send_word(-32'sd7, 1'b0);
        send_word(32'sd5, 1'b1);
        send_word(32'sd3, 1'b0);
        send_word(32'sd2, 1'b0);
        send_word(32'sd1, 1'b0);
        send_word(-32'sd1, 1'b1);
        drain();

        while (words_sent < N_WORDS) begin
            send_random_set();
            if (words_sent >= N_WORDS / 2 && words_sent < N_WORDS / 2 + 30) begin
                drain();
            end
        end
        start <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("PASS median_of_sample_set");
        end else begin
            $display("FAIL median_of_sample_set");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAIL median_of_sample_set");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/msc_pkg.sv
rtl/core/msc_cell.sv
rtl/core/median_of_sample_set.sv
tb/sv/tb_median_of_sample_set.sv
